@@ sv/cbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbb_pkg;

    localparam int COORD_BITS = 21;
    localparam int FRAC_BITS  = 2;
    localparam int QW         = COORD_BITS + FRAC_BITS;
    localparam int RW         = QW + 1;
    localparam int OW         = COORD_BITS + 1;
    localparam int HW_BITS    = 10;
    localparam int MODE_BITS  = 2;
    localparam int NCAND      = 6;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REG_PATH_MODE  = 1'b0;
    localparam logic REG_HALF_WIDTH = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_POLY   = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_CLOSED = 2'd2,
        MODE_INTERP = 2'd3
    } t_mode;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [QW-1:0]         t_qval;
    typedef logic signed [OW-1:0]         t_oval;

    // one classified point: candidate set plus flags for the box engine
    typedef struct packed {
        logic                        set;
        logic                        last;
        logic                        err;
        logic [NCAND-1:0][QW-1:0]    cx;
        logic [NCAND-1:0][QW-1:0]    cy;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/cbb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire cbb_pkg::t_mode i_mode,
    input  wire cbb_pkg::t_coord i_point_x,
    input  wire cbb_pkg::t_coord i_point_y,
    input  wire cbb_pkg::t_coord i_left_ctrl_x,
    input  wire cbb_pkg::t_coord i_left_ctrl_y,
    input  wire cbb_pkg::t_coord i_right_ctrl_x,
    input  wire cbb_pkg::t_coord i_right_ctrl_y,
    input  wire logic           i_last_point,
    input  wire logic           i_full,
    output logic                o_push,
    output cbb_pkg::t_cmd       o_cmd
);
    import cbb_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_coord     r_px, r_py, r_prx, r_pry;
    logic       approx;
    logic       accept;

    function automatic t_qval sx(input t_coord v);
        return t_qval'({{FRAC_BITS{v[COORD_BITS-1]}}, v});
    endfunction

    function automatic t_qval q4(input t_coord v);
        return t_qval'({v, {FRAC_BITS{1'b0}}});
    endfunction

    // one axis: candidates for the current mode and count
    function automatic logic [NCAND-1:0][QW-1:0] cands(
        input t_mode m, input logic [1:0] cnt, input logic last,
        input t_coord p, input t_coord pr, input t_coord l, input t_coord c);
        logic [NCAND-1:0][QW-1:0] r;
        t_qval a, b, f;
        a = (sx(p) <<< 1) + sx(p) + sx(c);
        b = sx(p) + (sx(c) <<< 1) + sx(c);
        f = q4(c);
        for (int k = 0; k < NCAND; k++) begin
            r[k] = f;
        end
        if (cnt != 2'd0) begin
            case (m)
                MODE_POLY: begin
                    r[0] = f;
                end
                MODE_OPEN, MODE_CLOSED: begin
                    if (cnt == 2'd1) begin
                        r[0] = (m == MODE_CLOSED) ? a : q4(p);
                    end else begin
                        r[0] = a;
                    end
                    r[1] = b;
                    r[2] = (m == MODE_OPEN && last) ? f : r[0];
                    for (int k = 3; k < NCAND; k++) begin
                        r[k] = r[0];
                    end
                end
                MODE_INTERP: begin
                    r[0] = q4(p);
                    r[1] = (sx(p) + sx(pr)) <<< 1;
                    r[2] = sx(p) + (sx(pr) <<< 1) + sx(l);
                    r[3] = sx(pr) + (sx(l) <<< 1) + sx(c);
                    r[4] = (sx(l) + sx(c)) <<< 1;
                    r[5] = f;
                end
                default: begin
                    r[0] = f;
                end
            endcase
        end
        return r;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign approx  = (i_mode == MODE_OPEN) || (i_mode == MODE_CLOSED);

    always_comb begin
        o_cmd.last = i_last_point;
        o_cmd.err  = i_last_point && approx && (r_cnt == 2'd0);
        o_cmd.set  = (r_cnt == 2'd0) || (approx && r_cnt == 2'd1);
        o_cmd.cx   = cands(i_mode, r_cnt, i_last_point, r_px, r_prx, i_left_ctrl_x, i_point_x);
        o_cmd.cy   = cands(i_mode, r_cnt, i_last_point, r_py, r_pry, i_left_ctrl_y, i_point_y);
        if (i_last_point) begin
            n_cnt = 2'd0;
        end else if (r_cnt < 2'd2) begin
            n_cnt = r_cnt + 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_prx <= i_right_ctrl_x;
            r_pry <= i_right_ctrl_y;
        end
    end

endmodule

`default_nettype wire

@@ sv/cbb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cbb_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output cbb_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import cbb_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/cbb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbb_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire cbb_pkg::t_cmd                 i_cmd,
    output logic                               o_pop,
    input  wire logic [cbb_pkg::HW_BITS-1:0]   i_half_width,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output cbb_pkg::t_oval                     o_box_xmin,
    output cbb_pkg::t_oval                     o_box_ymin,
    output cbb_pkg::t_oval                     o_box_xmax,
    output cbb_pkg::t_oval                     o_box_ymax,
    output logic                               o_status
);
    import cbb_pkg::*;

    t_qval r_xmin, r_ymin, r_xmax, r_ymax;
    t_qval n_xmin, n_ymin, n_xmax, n_ymax;
    t_qval r_oxmin, r_oymin, r_oxmax, r_oymax;
    logic  r_err;
    logic  r_out_valid;
    logic  signed [RW-1:0] hw;

    function automatic t_qval vmin(input t_qval s, input logic [NCAND-1:0][QW-1:0] c);
        t_qval m;
        m = s;
        for (int k = 0; k < NCAND; k++) begin
            if ($signed(c[k]) < m) m = $signed(c[k]);
        end
        return m;
    endfunction

    function automatic t_qval vmax(input t_qval s, input logic [NCAND-1:0][QW-1:0] c);
        t_qval m;
        m = s;
        for (int k = 0; k < NCAND; k++) begin
            if ($signed(c[k]) > m) m = $signed(c[k]);
        end
        return m;
    endfunction

    // quarter units to whole units, half away from zero
    function automatic logic signed [RW-1:0] rnd(input t_qval v);
        logic signed [RW-1:0] e;
        e = RW'(v);
        e = e + (v[QW-1] ? RW'(1) : RW'(2));
        return e >>> FRAC_BITS;
    endfunction

    assign o_pop = i_valid && (!i_cmd.last || !r_out_valid || i_out_ready);
    assign hw    = RW'(i_half_width);

    always_comb begin
        n_xmin = vmin(i_cmd.set ? t_qval'(i_cmd.cx[0]) : r_xmin, i_cmd.cx);
        n_xmax = vmax(i_cmd.set ? t_qval'(i_cmd.cx[0]) : r_xmax, i_cmd.cx);
        n_ymin = vmin(i_cmd.set ? t_qval'(i_cmd.cy[0]) : r_ymin, i_cmd.cy);
        n_ymax = vmax(i_cmd.set ? t_qval'(i_cmd.cy[0]) : r_ymax, i_cmd.cy);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_xmin <= n_xmin;
            r_xmax <= n_xmax;
            r_ymin <= n_ymin;
            r_ymax <= n_ymax;
        end
        if (o_pop && i_cmd.last) begin
            r_oxmin <= n_xmin;
            r_oxmax <= n_xmax;
            r_oymin <= n_ymin;
            r_oymax <= n_ymax;
            r_err   <= i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cmd.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_err;
    assign o_box_xmin  = r_err ? '0 : OW'(rnd(r_oxmin) - hw);
    assign o_box_ymin  = r_err ? '0 : OW'(rnd(r_oymin) - hw);
    assign o_box_xmax  = r_err ? '0 : OW'(rnd(r_oxmax) + hw);
    assign o_box_ymax  = r_err ? '0 : OW'(rnd(r_oymax) + hw);

endmodule

`default_nettype wire

@@ sv/curve_bounding_box_accumulator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------
// points   | i_in_valid / o_in_ready | point, left/right control, last_point
// box      | o_out_valid/i_out_ready | box_xmin/ymin/xmax/ymax, status
// config   | APB psel/penable/pwrite | path_mode @0x0, half_width @0x4
//
// One point per cycle while the queue is not full; a path's box appears in the
// cycle after its last point leaves the two-entry queue, set by the back-end
// min/max stage. Unstalled, the last point passes a queue entry, then the result register.
// Synchronous active-low reset empties the queue and the result register.
// A waiting box holds the next path's last point at the queue head; input
// stalls once the queue fills behind it.
module curve_bounding_box_accumulator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire cbb_pkg::t_coord               i_point_x,
    input  wire cbb_pkg::t_coord               i_point_y,
    input  wire cbb_pkg::t_coord               i_left_ctrl_x,
    input  wire cbb_pkg::t_coord               i_left_ctrl_y,
    input  wire cbb_pkg::t_coord               i_right_ctrl_x,
    input  wire cbb_pkg::t_coord               i_right_ctrl_y,
    input  wire logic                          i_last_point,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output cbb_pkg::t_oval                     o_box_xmin,
    output cbb_pkg::t_oval                     o_box_ymin,
    output cbb_pkg::t_oval                     o_box_xmax,
    output cbb_pkg::t_oval                     o_box_ymax,
    output logic                               o_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbb_pkg::APB_AW-1:0]    paddr,
    input  wire logic [cbb_pkg::APB_DW-1:0]    pwdata,
    output logic [cbb_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import cbb_pkg::*;

    t_mode               r_mode;
    logic [HW_BITS-1:0]  r_half_width;
    logic                wr_en;
    logic                full, push, q_valid, pop;
    t_cmd                f_cmd, q_cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_POLY;
            r_half_width <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_PATH_MODE:  r_mode       <= t_mode'(pwdata[MODE_BITS-1:0]);
                REG_HALF_WIDTH: r_half_width <= pwdata[HW_BITS-1:0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PATH_MODE:  prdata = {{(APB_DW-MODE_BITS){1'b0}}, r_mode};
            REG_HALF_WIDTH: prdata = {{(APB_DW-HW_BITS){1'b0}}, r_half_width};
            default:        prdata = '0;
        endcase
    end

    cbb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_mode         (r_mode),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_left_ctrl_x  (i_left_ctrl_x),
        .i_left_ctrl_y  (i_left_ctrl_y),
        .i_right_ctrl_x (i_right_ctrl_x),
        .i_right_ctrl_y (i_right_ctrl_y),
        .i_last_point   (i_last_point),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (f_cmd)
    );

    cbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    cbb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .i_half_width (r_half_width),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_box_xmin   (o_box_xmin),
        .o_box_ymin   (o_box_ymin),
        .o_box_xmax   (o_box_xmax),
        .o_box_ymax   (o_box_ymax),
        .o_status     (o_status)
    );

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("reset did not clear the pipeline");

    a_err_zero_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
        (o_box_xmin == '0 && o_box_ymin == '0 && o_box_xmax == '0 && o_box_ymax == '0))
        else $error("error transaction carries a non-zero box");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_box_xmin <= o_box_xmax && o_box_ymin <= o_box_ymax))
        else $error("box edges out of order");
`endif

endmodule

`default_nettype wire
